>>> design/isgbd_pkg.sv
package isgbd_pkg;

    // Field widths fixed by the sample and result formats
    localparam int TS_W     = 48;
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_MEAN_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MEAN_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_VAR_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_VAR_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_MAG = 3'd5;

    // Configuration reset values
    localparam logic [23:0] RST_WINDOW_DURATION = 24'd1000000;
    localparam logic [30:0] RST_GYRO_MEAN_LIMIT = 31'd10486;
    localparam logic [30:0] RST_ACCEL_MEAN_LIMIT = 31'd19661;
    localparam logic [47:0] RST_GYRO_VAR_LIMIT = 48'd1099512;
    localparam logic [47:0] RST_ACCEL_VAR_LIMIT = 48'd42950;
    localparam logic [23:0] RST_GRAVITY_MAG = 24'd642908;

    typedef struct packed {
        logic [23:0] window_duration_us;
        logic [30:0] gyro_mean_limit;
        logic [30:0] accel_mean_limit;
        logic [47:0] gyro_var_limit;
        logic [47:0] accel_var_limit;
        logic [23:0] gravity_mag;
    } cfg_t;

    // One classified command waiting in the queue
    typedef struct packed {
        logic                              is_clear;
        logic [TS_W-1:0]                   ts;
        logic [2:0][SAMPLE_W-1:0]          gyro;
        logic [2:0][SAMPLE_W-1:0]          accel;
    } cmd_t;

    // One row of the sample store
    typedef struct packed {
        logic [TS_W-1:0]                   ts;
        logic [2:0][SAMPLE_W-1:0]          gyro;
        logic [2:0][SAMPLE_W-1:0]          accel;
    } row_t;

endpackage

>>> design/isgbd_if.sv
interface isgbd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [isgbd_pkg::TS_W-1:0]            timestamp_us;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] gyro_x;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] gyro_y;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] gyro_z;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] accel_z;

    modport source (
        output valid, operation, timestamp_us, gyro_x, gyro_y, gyro_z,
               accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, operation, timestamp_us, gyro_x, gyro_y, gyro_z,
               accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface isgbd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  bias_ready;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] bias_gyro_x;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] bias_gyro_y;
    logic signed [isgbd_pkg::SAMPLE_W-1:0] bias_gyro_z;
    logic [isgbd_pkg::COUNT_W-1:0]         stored_count;

    modport source (
        output valid, bias_ready, bias_gyro_x, bias_gyro_y, bias_gyro_z, stored_count,
        input  ready
    );
    modport sink (
        input  valid, bias_ready, bias_gyro_x, bias_gyro_y, bias_gyro_z, stored_count,
        output ready
    );
endinterface

>>> design/isgbd_front.sv
module isgbd_front (
    input  logic               clk,
    input  logic               rst_n,
    isgbd_in_if.sink           sample_in,
    output logic               q_valid,
    output isgbd_pkg::cmd_t    q_data,
    input  logic               q_pop
);

    isgbd_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            push;
    isgbd_pkg::cmd_t cmd;

    // Classify the incoming transaction
    always_comb
    begin
        cmd.is_clear = (sample_in.operation == isgbd_pkg::OP_CLEAR);
        cmd.ts       = sample_in.timestamp_us;
        cmd.gyro     = {sample_in.gyro_z, sample_in.gyro_y, sample_in.gyro_x};
        cmd.accel    = {sample_in.accel_z, sample_in.accel_y, sample_in.accel_x};
    end

    assign sample_in.ready = (fill_reg != 2'd2);
    assign push            = sample_in.valid && sample_in.ready;
    assign q_valid         = (fill_reg != 2'd0);
    assign q_data          = slot_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

>>> design/isgbd_div.sv
module isgbd_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             ge;

    // One restoring step: shift in a numerator bit, subtract if it fits
    assign shifted = {rem_reg, work_reg[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quot    = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            work_reg <= num;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            work_reg <= {work_reg[NUM_W-2:0], ge};
        end
    end

endmodule

>>> design/isgbd_back.sv
module isgbd_back #(
    parameter int WINDOW_DEPTH      = 1024,
    parameter int MIN_CHECK_SAMPLES = 10,
    parameter int MIN_SPAN_SAMPLES  = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  isgbd_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  isgbd_pkg::cmd_t    q_data,
    output logic               q_pop,
    isgbd_out_if.source        result_out
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SW     = isgbd_pkg::SAMPLE_W;
    localparam int SUM_W  = SW + CNT_W;
    localparam int MAG_W  = SW + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int OUT_CW = isgbd_pkg::COUNT_W;
    localparam int TSW    = isgbd_pkg::TS_W;
    localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [63:0] SumCap = 64'h8000_0000_0000_0000;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SPAN_RD  = 4'd1;
    localparam logic [3:0] S_SPAN_CHK = 4'd2;
    localparam logic [3:0] S_SUM      = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_NORM     = 4'd5;
    localparam logic [3:0] S_MCHK     = 4'd6;
    localparam logic [3:0] S_DEV      = 4'd7;
    localparam logic [3:0] S_VAR      = 4'd8;
    localparam logic [3:0] S_VCHK     = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    // Product destinations
    localparam logic [2:0] MS_GN   = 3'd0;
    localparam logic [2:0] MS_AN   = 3'd1;
    localparam logic [2:0] MS_GML  = 3'd2;
    localparam logic [2:0] MS_HI   = 3'd3;
    localparam logic [2:0] MS_LO   = 3'd4;
    localparam logic [2:0] MS_GDEV = 3'd5;
    localparam logic [2:0] MS_ADEV = 3'd6;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LastSlot) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] t);
        logic [63:0] room;
        room = SumCap - t;
        return (acc > room) ? SumCap : acc + t;
    endfunction

    // Control registers
    logic [3:0]        state_reg, state_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              latched_reg, latched_next;
    logic              checked_reg, checked_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [3:0]        step_reg, step_next;
    logic              div_run_reg, div_run_next;
    logic              out_valid_reg, out_valid_next;
    logic              prod_vld_reg;
    logic [2:0]        prod_sel_reg;

    // Datapath registers
    logic signed [SW-1:0]    bias_reg [3];
    logic [TSW-1:0]          newest_ts_reg;
    logic signed [SUM_W-1:0] sum_reg [6];
    logic signed [SW-1:0]    mean_reg [6];
    logic [MAG_W-1:0]        diff_reg [6];
    logic [63:0]             gn_reg, an_reg, gml_sq_reg, hi_sq_reg, lo_sq_reg;
    logic [63:0]             gdev_reg, adev_reg, gvl_prod_reg, avl_prod_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    out_bias_ready_reg;
    logic signed [SW-1:0]    out_bias_reg [3];
    logic [OUT_CW-1:0]       out_count_reg;

    // Sample store
    isgbd_pkg::row_t   mem [WINDOW_DEPTH];
    isgbd_pkg::row_t   mem_q;
    isgbd_pkg::row_t   wr_row;
    logic              mem_we;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_slot;

    logic                    full;
    logic [SLOT_W-1:0]       ins_oldest;
    logic [CNT_W-1:0]        ins_count;
    logic [SLOT_W:0]         wr_wide;
    logic [TSW-1:0]          span;
    logic                    span_over;
    logic signed [SW-1:0]    row_val [6];
    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        div_num;
    logic [SUM_W-1:0]        div_quot;
    logic [2:0]              dsel;
    logic                    mul_issue;
    logic [2:0]              mul_sel;
    logic [MAG_W-1:0]        mul_a;
    logic [MAG_W-1:0]        mul_b;
    logic [31:0]             hi_val;
    logic [31:0]             lo_val;
    logic                    grav_ge;
    logic                    mean_pass;
    logic                    var_pass;
    logic                    out_load;

    // Slot of a new sample, dropping the oldest when the store is full
    always_comb
    begin
        full       = (count_reg == CNT_W'(WINDOW_DEPTH));
        ins_oldest = full ? slot_inc(oldest_reg) : oldest_reg;
        ins_count  = full ? CNT_W'(WINDOW_DEPTH - 1) : count_reg;
        wr_wide    = (SLOT_W + 1)'(ins_oldest) + (SLOT_W + 1)'(ins_count);
        wr_slot    = (wr_wide >= (SLOT_W + 1)'(WINDOW_DEPTH))
                     ? SLOT_W'(wr_wide - (SLOT_W + 1)'(WINDOW_DEPTH))
                     : SLOT_W'(wr_wide);
        wr_row.ts    = q_data.ts;
        wr_row.gyro  = q_data.gyro;
        wr_row.accel = q_data.accel;
    end

    // Window span against the oldest stored timestamp
    always_comb
    begin
        span      = (newest_ts_reg >= mem_q.ts) ? newest_ts_reg - mem_q.ts
                                                : mem_q.ts - newest_ts_reg;
        span_over = (span > TSW'(cfg.window_duration_us));
    end

    // Unpack the stored row, gyro first
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_val[k]     = $signed(mem_q.gyro[k]);
            row_val[k + 3] = $signed(mem_q.accel[k]);
        end
    end

    assign dsel    = step_reg[2:0];
    assign div_num = sum_reg[dsel][SUM_W-1] ? SUM_W'(-sum_reg[dsel]) : SUM_W'(sum_reg[dsel]);

    assign grav_ge   = ({7'd0, cfg.gravity_mag} >= cfg.accel_mean_limit);
    assign hi_val    = 32'(cfg.gravity_mag) + 32'(cfg.accel_mean_limit);
    assign lo_val    = 32'(cfg.gravity_mag) - 32'(cfg.accel_mean_limit);
    assign mean_pass = (gn_reg < gml_sq_reg) && (an_reg < hi_sq_reg)
                       && (!grav_ge || (an_reg > lo_sq_reg));
    assign var_pass  = (gdev_reg < gvl_prod_reg) && (adev_reg < avl_prod_reg);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || result_out.ready);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        latched_next   = latched_reg;
        checked_next   = checked_reg;
        idx_next       = idx_reg;
        rd_slot_next   = rd_slot_reg;
        rd_vld_next    = rd_vld_reg;
        step_next      = step_reg;
        div_run_next   = div_run_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = oldest_reg;
        div_start      = 1'b0;
        mul_issue      = 1'b0;
        mul_sel        = MS_GN;
        mul_a          = '0;
        mul_b          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_data.is_clear)
                    begin
                        oldest_next = '0;
                        count_next  = '0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        mem_we       = 1'b1;
                        oldest_next  = ins_oldest;
                        count_next   = ins_count + 1'b1;
                        checked_next = 1'b0;
                        state_next   = S_SPAN_RD;
                    end
                end
            end
            S_SPAN_RD:
            begin
                if (int'(count_reg) < MIN_SPAN_SAMPLES)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SPAN_CHK;
                end
            end
            S_SPAN_CHK:
            begin
                if (span_over)
                begin
                    if (!checked_reg && !latched_reg)
                    begin
                        checked_next = 1'b1;
                        if (int'(count_reg) >= MIN_CHECK_SAMPLES)
                        begin
                            idx_next     = '0;
                            rd_slot_next = oldest_reg;
                            rd_vld_next  = 1'b0;
                            state_next   = S_SUM;
                        end
                    end
                    else
                    begin
                        oldest_next = slot_inc(oldest_reg);
                        count_next  = count_reg - 1'b1;
                        state_next  = S_SPAN_RD;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SUM:
            begin
                rd_addr = rd_slot_reg;
                if (idx_reg != count_reg)
                begin
                    rd_slot_next = slot_inc(rd_slot_reg);
                    idx_next     = idx_reg + 1'b1;
                    rd_vld_next  = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg)
                    begin
                        step_next    = '0;
                        div_run_next = 1'b0;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_run_reg)
                begin
                    div_start    = 1'b1;
                    div_run_next = 1'b1;
                end
                else if (div_done)
                begin
                    div_run_next = 1'b0;
                    if (step_reg == 4'd5)
                    begin
                        step_next  = '0;
                        state_next = S_NORM;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            S_NORM:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg < 4'd6)
                begin
                    mul_issue = 1'b1;
                    mul_sel   = (step_reg < 4'd3) ? MS_GN : MS_AN;
                    mul_a     = MAG_W'(mean_reg[dsel][SW-1] ? -mean_reg[dsel] : mean_reg[dsel]);
                    mul_b     = mul_a;
                end
                else if (step_reg == 4'd6)
                begin
                    mul_issue = 1'b1;
                    mul_sel   = MS_GML;
                    mul_a     = MAG_W'(cfg.gyro_mean_limit);
                    mul_b     = mul_a;
                end
                else if (step_reg == 4'd7)
                begin
                    mul_issue = 1'b1;
                    mul_sel   = MS_HI;
                    mul_a     = MAG_W'(hi_val);
                    mul_b     = mul_a;
                end
                else if (step_reg == 4'd8)
                begin
                    mul_issue = 1'b1;
                    mul_sel   = MS_LO;
                    mul_a     = MAG_W'(lo_val);
                    mul_b     = mul_a;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (mean_pass)
                begin
                    idx_next     = '0;
                    rd_slot_next = oldest_reg;
                    step_next    = '0;
                    state_next   = S_DEV;
                end
                else
                begin
                    state_next = S_SPAN_RD;
                end
            end
            S_DEV:
            begin
                if (step_reg == 4'd0)
                begin
                    if (idx_reg != count_reg)
                    begin
                        rd_addr      = rd_slot_reg;
                        rd_slot_next = slot_inc(rd_slot_reg);
                        idx_next     = idx_reg + 1'b1;
                        step_next    = 4'd1;
                    end
                    else
                    begin
                        state_next = S_VAR;
                    end
                end
                else if (step_reg == 4'd1)
                begin
                    step_next = 4'd2;
                end
                else
                begin
                    mul_issue = 1'b1;
                    mul_sel   = (step_reg < 4'd5) ? MS_GDEV : MS_ADEV;
                    mul_a     = diff_reg[3'(step_reg - 4'd2)];
                    mul_b     = mul_a;
                    step_next = (step_reg == 4'd7) ? 4'd0 : step_reg + 1'b1;
                end
            end
            S_VAR:
            begin
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                if (var_pass)
                begin
                    latched_next = 1'b1;
                end
                state_next = S_SPAN_RD;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            latched_reg   <= 1'b0;
            checked_reg   <= 1'b0;
            idx_reg       <= '0;
            rd_slot_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            step_reg      <= '0;
            div_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_sel_reg  <= MS_GN;
            for (int k = 0; k < 3; k++)
            begin
                bias_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            latched_reg   <= latched_next;
            checked_reg   <= checked_next;
            idx_reg       <= idx_next;
            rd_slot_reg   <= rd_slot_next;
            rd_vld_reg    <= rd_vld_next;
            step_reg      <= step_next;
            div_run_reg   <= div_run_next;
            out_valid_reg <= out_valid_next;
            prod_vld_reg  <= mul_issue;
            prod_sel_reg  <= mul_sel;
            // Latch the gyro mean as the bias
            if ((state_reg == S_VCHK) && var_pass)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    bias_reg[k] <= mean_reg[k];
                end
            end
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_slot] <= wr_row;
        end
        mem_q <= mem[rd_addr];
    end

    // Shared squaring multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath updates
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && mem_we)
        begin
            newest_ts_reg <= q_data.ts;
        end

        // Clear the axis sums before a check, then add each row
        if (state_reg == S_SPAN_CHK)
        begin
            for (int k = 0; k < 6; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else if ((state_reg == S_SUM) && rd_vld_reg)
        begin
            for (int k = 0; k < 6; k++)
            begin
                sum_reg[k] <= sum_reg[k] + row_val[k];
            end
        end

        // Signed truncated mean from the magnitude quotient
        if ((state_reg == S_DIV) && div_run_reg && div_done)
        begin
            mean_reg[dsel] <= sum_reg[dsel][SUM_W-1] ? SW'(-div_quot) : SW'(div_quot);
        end

        if (state_reg == S_DIV)
        begin
            gn_reg <= '0;
            an_reg <= '0;
        end
        if (state_reg == S_MCHK)
        begin
            gdev_reg <= '0;
            adev_reg <= '0;
        end

        // Deviation magnitudes of the row just read
        if ((state_reg == S_DEV) && (step_reg == 4'd1))
        begin
            for (int k = 0; k < 6; k++)
            begin
                diff_reg[k] <= ($signed({row_val[k][SW-1], row_val[k]})
                                - $signed({mean_reg[k][SW-1], mean_reg[k]})) < 0
                               ? MAG_W'(-($signed({row_val[k][SW-1], row_val[k]})
                                          - $signed({mean_reg[k][SW-1], mean_reg[k]})))
                               : MAG_W'($signed({row_val[k][SW-1], row_val[k]})
                                        - $signed({mean_reg[k][SW-1], mean_reg[k]}));
            end
        end

        // Route each product
        if (prod_vld_reg)
        begin
            unique case (prod_sel_reg)
                MS_GN:   gn_reg     <= gn_reg + prod_reg[63:0];
                MS_AN:   an_reg     <= an_reg + prod_reg[63:0];
                MS_GML:  gml_sq_reg <= prod_reg[63:0];
                MS_HI:   hi_sq_reg  <= prod_reg[63:0];
                MS_LO:   lo_sq_reg  <= prod_reg[63:0];
                MS_GDEV: gdev_reg   <= sat_add(gdev_reg, prod_reg[63:0]);
                MS_ADEV: adev_reg   <= sat_add(adev_reg, prod_reg[63:0]);
                default: ;
            endcase
        end

        // Variance bounds scaled by n-1
        if (state_reg == S_VAR)
        begin
            gvl_prod_reg <= 64'(cfg.gyro_var_limit) * 64'(count_reg - 1'b1);
            avl_prod_reg <= 64'(cfg.accel_var_limit) * 64'(count_reg - 1'b1);
        end

        // Output register
        if (out_load)
        begin
            out_bias_ready_reg <= latched_reg;
            for (int k = 0; k < 3; k++)
            begin
                out_bias_reg[k] <= bias_reg[k];
            end
            out_count_reg <= OUT_CW'(count_reg);
        end
    end

    isgbd_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (count_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign result_out.valid        = out_valid_reg;
    assign result_out.bias_ready   = out_bias_ready_reg;
    assign result_out.bias_gyro_x  = out_bias_reg[0];
    assign result_out.bias_gyro_y  = out_bias_reg[1];
    assign result_out.bias_gyro_z  = out_bias_reg[2];
    assign result_out.stored_count = out_count_reg;

    // Store occupancy stays within its depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("sample count beyond store depth");

    // Once latched, the bias stays latched
    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |=> latched_reg)
        else $error("bias latch dropped");

    // A command is only taken from the queue when one is waiting and the sequencer is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && (state_reg == S_IDLE)))
        else $error("queue popped out of turn");

    // The divider only finishes while a division is running
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIV) && div_run_reg))
        else $error("stray divider completion");

endmodule

>>> design/imu_static_gyro_bias_detector.sv
// Static gyro bias detector. IMU samples enter a circular window store of
// WINDOW_DEPTH rows; once the timestamp span of the store exceeds the window
// length, no bias is latched yet and at least MIN_CHECK_SAMPLES rows are
// stored, a stillness check walks the store and, on success, latches the
// truncated gyro mean as the bias. Each accepted transaction yields exactly
// one result. A two-entry queue sits in front of the sequencer and a result
// register behind it. Each dropped old sample costs a further span
// evaluation through the single store read port. A stillness check adds a
// sum pass over the store, 6 serial divisions, the norm products and a
// deviation pass, which is bound by the single shared squaring multiplier.
// Configuration is written by index through cfg_we, cfg_index and cfg_data.
module imu_static_gyro_bias_detector #(
    parameter int WINDOW_DEPTH      = 1024,
    parameter int MIN_CHECK_SAMPLES = 10,
    parameter int MIN_SPAN_SAMPLES  = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [isgbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isgbd_pkg::CFG_DATA_W-1:0]      cfg_data,
    isgbd_in_if.sink                              sample_in,
    isgbd_out_if.source                           result_out
);

    isgbd_pkg::cfg_t cfg_reg;
    isgbd_pkg::cmd_t q_data;
    logic            q_valid;
    logic            q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_duration_us <= isgbd_pkg::RST_WINDOW_DURATION;
            cfg_reg.gyro_mean_limit    <= isgbd_pkg::RST_GYRO_MEAN_LIMIT;
            cfg_reg.accel_mean_limit   <= isgbd_pkg::RST_ACCEL_MEAN_LIMIT;
            cfg_reg.gyro_var_limit     <= isgbd_pkg::RST_GYRO_VAR_LIMIT;
            cfg_reg.accel_var_limit    <= isgbd_pkg::RST_ACCEL_VAR_LIMIT;
            cfg_reg.gravity_mag        <= isgbd_pkg::RST_GRAVITY_MAG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                isgbd_pkg::CFG_WINDOW_DURATION:  cfg_reg.window_duration_us <= cfg_data[23:0];
                isgbd_pkg::CFG_GYRO_MEAN_LIMIT:  cfg_reg.gyro_mean_limit    <= cfg_data[30:0];
                isgbd_pkg::CFG_ACCEL_MEAN_LIMIT: cfg_reg.accel_mean_limit   <= cfg_data[30:0];
                isgbd_pkg::CFG_GYRO_VAR_LIMIT:   cfg_reg.gyro_var_limit     <= cfg_data[47:0];
                isgbd_pkg::CFG_ACCEL_VAR_LIMIT:  cfg_reg.accel_var_limit    <= cfg_data[47:0];
                isgbd_pkg::CFG_GRAVITY_MAG:      cfg_reg.gravity_mag        <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    isgbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    isgbd_back #(
        .WINDOW_DEPTH      (WINDOW_DEPTH),
        .MIN_CHECK_SAMPLES (MIN_CHECK_SAMPLES),
        .MIN_SPAN_SAMPLES  (MIN_SPAN_SAMPLES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .result_out (result_out)
    );

endmodule

>>> dv/tb_imu_static_gyro_bias_detector.sv
`timescale 1ns / 100ps

module tb_imu_static_gyro_bias_detector;
    import isgbd_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int MIN_CHECK  = 10;
    localparam int MIN_SPAN   = 3;
    localparam int IDLE_PCT   = 34;
    localparam int WDOG_LIMIT = 40000;
    localparam bit [63:0] SAT_CAP = 64'h8000_0000_0000_0000;

    typedef struct {
        logic        op;
        bit [47:0]   ts;
        longint      gyro [3];
        longint      accel [3];
    } imu_txn_t;

    typedef struct {
        bit          ready;
        bit [31:0]   bias [3];
        bit [10:0]   count;
    } bias_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    isgbd_in_if  sample_in ();
    isgbd_out_if result_out ();

    imu_static_gyro_bias_detector dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .result_out (result_out)
    );

    always #1 clk = ~clk;

    // Model state: registers, window store, latched bias
    bit [63:0] win_len, gm_lim, am_lim, gv_lim, av_lim, grav;
    bit [47:0] ts_mem [DEPTH];
    longint    gyro_mem [3*DEPTH];
    longint    accel_mem [3*DEPTH];
    int        head, fill;
    bit        latched;
    longint    bias_val [3];

    imu_txn_t  pending_q [$];
    bias_res_t expected_q [$];
    int        errors = 0;
    bit        in_fire = 1'b0;
    bit        quiet = 1'b0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        results_seen = 0;
    int        wdog = 0;

    function automatic int slot(int i);
        return (head + i) % DEPTH;
    endfunction

    function automatic bit [63:0] sq_mag(longint v);
        bit [63:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic bit [63:0] span_now();
        bit [47:0] a, b;
        if (fill < MIN_SPAN) return 0;
        a = ts_mem[head];
        b = ts_mem[slot(fill - 1)];
        return (b >= a) ? b - a : a - b;
    endfunction

    function automatic bit [63:0] dev_total(bit use_gyro, longint mean [3]);
        bit [63:0] acc, t;
        longint v;
        acc = 0;
        for (int i = 0; i < fill; i++)
            for (int k = 0; k < 3; k++)
            begin
                v = use_gyro ? gyro_mem[3*slot(i)+k] : accel_mem[3*slot(i)+k];
                t = sq_mag(v - mean[k]);
                acc = (acc > SAT_CAP - t) ? SAT_CAP : acc + t;
            end
        return acc;
    endfunction

    // Stillness check over the whole store; latch the mean on success
    function automatic bit stillness();
        longint gs [3], as_ [3], gm [3], am [3];
        bit [63:0] n, gn, an, hi, lo;
        n = fill;
        if (n < MIN_CHECK || n < 2) return 0;
        for (int k = 0; k < 3; k++)
        begin
            gs[k] = 0;
            as_[k] = 0;
        end
        for (int i = 0; i < fill; i++)
            for (int k = 0; k < 3; k++)
            begin
                gs[k] += gyro_mem[3*slot(i)+k];
                as_[k] += accel_mem[3*slot(i)+k];
            end
        for (int k = 0; k < 3; k++)
        begin
            gm[k] = gs[k] / longint'(n);
            am[k] = as_[k] / longint'(n);
        end
        gn = sq_mag(gm[0]) + sq_mag(gm[1]) + sq_mag(gm[2]);
        an = sq_mag(am[0]) + sq_mag(am[1]) + sq_mag(am[2]);
        if (!(gn < gm_lim * gm_lim)) return 0;
        hi = grav + am_lim;
        if (!(an < hi * hi)) return 0;
        if (grav >= am_lim)
        begin
            lo = grav - am_lim;
            if (!(an > lo * lo)) return 0;
        end
        if (!(dev_total(1, gm) < gv_lim * (n - 1))) return 0;
        if (!(dev_total(0, am) < av_lim * (n - 1))) return 0;
        for (int k = 0; k < 3; k++) bias_val[k] = gm[k];
        return 1;
    endfunction

    function automatic bias_res_t predict_bias(imu_txn_t t);
        bias_res_t r;
        int s;
        if (t.op == OP_CLEAR)
        begin
            head = 0;
            fill = 0;
        end
        else
        begin
            if (fill >= DEPTH)
            begin
                head = slot(1);
                fill = DEPTH - 1;
            end
            s = slot(fill);
            ts_mem[s] = t.ts;
            for (int k = 0; k < 3; k++)
            begin
                gyro_mem[3*s+k] = t.gyro[k];
                accel_mem[3*s+k] = t.accel[k];
            end
            fill++;
            if (span_now() > win_len)
            begin
                if (!latched) latched = stillness();
                while (span_now() > win_len)
                begin
                    head = slot(1);
                    fill--;
                end
            end
        end
        r.ready = latched;
        for (int k = 0; k < 3; k++) r.bias[k] = bias_val[k][31:0];
        r.count = fill[10:0];
        return r;
    endfunction

    // Input driver: present the next pending transaction at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_in.valid <= 1'b0;
        else if (!sample_in.valid || in_fire)
        begin
            if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                imu_txn_t t;
                t = pending_q.pop_front();
                sample_in.valid        <= 1'b1;
                sample_in.operation    <= t.op;
                sample_in.timestamp_us <= t.ts;
                sample_in.gyro_x       <= t.gyro[0][31:0];
                sample_in.gyro_y       <= t.gyro[1][31:0];
                sample_in.gyro_z       <= t.gyro[2][31:0];
                sample_in.accel_x      <= t.accel[0][31:0];
                sample_in.accel_y      <= t.accel[1][31:0];
                sample_in.accel_z      <= t.accel[2][31:0];
            end
            else
                sample_in.valid <= 1'b0;
        end
    end

    initial
    begin
        sample_in.valid = 1'b0;
        sample_in.operation = OP_SAMPLE;
        sample_in.timestamp_us = '0;
        sample_in.gyro_x = '0;
        sample_in.gyro_y = '0;
        sample_in.gyro_z = '0;
        sample_in.accel_x = '0;
        sample_in.accel_y = '0;
        sample_in.accel_z = '0;
        result_out.ready = 1'b0;
    end

    // Predict on every accepted input transaction
    always @(posedge clk)
    begin
        in_fire <= sample_in.valid && sample_in.ready;
        if (rst_n && sample_in.valid && sample_in.ready)
        begin
            imu_txn_t t;
            t.op = sample_in.operation;
            t.ts = sample_in.timestamp_us;
            t.gyro[0] = sample_in.gyro_x;
            t.gyro[1] = sample_in.gyro_y;
            t.gyro[2] = sample_in.gyro_z;
            t.accel[0] = sample_in.accel_x;
            t.accel[1] = sample_in.accel_y;
            t.accel[2] = sample_in.accel_z;
            expected_q.push_back(predict_bias(t));
        end
    end

    // Result back-pressure, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_out.ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 60)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            result_out.ready <= 1'b0;
        end
        else
            result_out.ready <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
    end

    // Result monitor: compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            bias_res_t e;
            bit bad;
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result, count %0d",
                    result_out.stored_count);
            end
            else
            begin
                e = expected_q.pop_front();
                bad = (result_out.bias_ready !== e.ready)
                   || (result_out.bias_gyro_x !== e.bias[0])
                   || (result_out.bias_gyro_y !== e.bias[1])
                   || (result_out.bias_gyro_z !== e.bias[2])
                   || (result_out.stored_count !== e.count);
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp rdy=%0b b=%0d,%0d,%0d n=%0d got rdy=%0b b=%0d,%0d,%0d n=%0d",
                            e.ready, $signed(e.bias[0]), $signed(e.bias[1]),
                            $signed(e.bias[2]), e.count, result_out.bias_ready,
                            result_out.bias_gyro_x, result_out.bias_gyro_y,
                            result_out.bias_gyro_z, result_out.stored_count);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((sample_in.valid && sample_in.ready) || (result_out.valid && result_out.ready)
            || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [47:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            CFG_WINDOW_DURATION:  win_len = val[23:0];
            CFG_GYRO_MEAN_LIMIT:  gm_lim = val[30:0];
            CFG_ACCEL_MEAN_LIMIT: am_lim = val[30:0];
            CFG_GYRO_VAR_LIMIT:   gv_lim = val;
            CFG_ACCEL_VAR_LIMIT:  av_lim = val;
            CFG_GRAVITY_MAG:      grav = val[23:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(bit [47:0] w, bit [47:0] gm, bit [47:0] am,
                             bit [47:0] gv, bit [47:0] av, bit [47:0] g);
        write_reg(CFG_WINDOW_DURATION, w);
        write_reg(CFG_GYRO_MEAN_LIMIT, gm);
        write_reg(CFG_ACCEL_MEAN_LIMIT, am);
        write_reg(CFG_GYRO_VAR_LIMIT, gv);
        write_reg(CFG_ACCEL_VAR_LIMIT, av);
        write_reg(CFG_GRAVITY_MAG, g);
    endtask

    task automatic push_imu(logic op, bit [47:0] ts, longint g0, longint g1, longint g2,
                            longint a0, longint a1, longint a2);
        imu_txn_t t;
        t.op = op;
        t.ts = ts;
        t.gyro[0] = g0;
        t.gyro[1] = g1;
        t.gyro[2] = g2;
        t.accel[0] = a0;
        t.accel[1] = a1;
        t.accel[2] = a2;
        pending_q.push_back(t);
    endtask

    function automatic longint rnd32();
        return longint'(int'($urandom));
    endfunction

    // Drain: hold off until every expectation is met, then settle
    task automatic drain();
        wait (pending_q.size() == 0 && !sample_in.valid && expected_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        bit [47:0] ts;
        longint jitter;
        win_len = RST_WINDOW_DURATION;
        gm_lim = RST_GYRO_MEAN_LIMIT;
        am_lim = RST_ACCEL_MEAN_LIMIT;
        gv_lim = RST_GYRO_VAR_LIMIT;
        av_lim = RST_ACCEL_VAR_LIMIT;
        grav = RST_GRAVITY_MAG;
        head = 0;
        fill = 0;
        latched = 0;
        for (int k = 0; k < 3; k++) bias_val[k] = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, decreasing timestamps, clear with junk fields
        push_imu(OP_SAMPLE, 48'd0, -2147483648, -2147483648, -2147483648,
                 -2147483648, -2147483648, -2147483648);
        push_imu(OP_SAMPLE, 48'hFFFF_FFFF_FFFF, 2147483647, 2147483647, 2147483647,
                 2147483647, 2147483647, 2147483647);
        push_imu(OP_SAMPLE, 48'd5, 0, 0, 0, 0, 0, 0);
        push_imu(OP_SAMPLE, 48'd2000000, -1, 1, -1, 1, -1, 1);
        push_imu(OP_SAMPLE, 48'd1000, 7, 8, 9, 10, 11, 12);
        push_imu(OP_SAMPLE, 48'd500, 7, 8, 9, 10, 11, 12);
        push_imu(OP_SAMPLE, 48'd0, 7, 8, 9, 10, 11, 12);
        push_imu(OP_CLEAR, 48'hFFFF_FFFF_FFFF, rnd32(), rnd32(), rnd32(),
                 rnd32(), rnd32(), rnd32());
        push_imu(OP_CLEAR, 48'd0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 12; i++)
            push_imu(OP_SAMPLE, 48'd3000000 - i * 200000, rnd32(), rnd32(), rnd32(),
                     rnd32(), rnd32(), rnd32());
        drain();

        // Noise with zero window, wide limits and zero gravity
        write_all(48'd0, 48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 48'd0);
        ts = {16'($urandom), 32'($urandom)};
        for (int i = 0; i < 45; i++)
        begin
            if ($urandom_range(3) == 0) ts = {16'($urandom), 32'($urandom)};
            push_imu($urandom_range(9) == 0 ? OP_CLEAR : OP_SAMPLE, ts, rnd32(), rnd32(),
                     rnd32(), rnd32(), rnd32(), rnd32());
        end
        drain();

        // Overfill the store with no idling, then force one check over a full store
        quiet = 1'b1;
        write_all(48'hFF_FFFF, 48'd0, 48'd0, 48'd0, 48'd0, 48'hFF_FFFF);
        for (int i = 0; i < DEPTH + 6; i++)
            push_imu(OP_SAMPLE, 48'd777, rnd32(), rnd32(), rnd32(),
                     rnd32(), rnd32(), rnd32());
        push_imu(OP_SAMPLE, 48'd777 + 48'h100_0005, 1, 2, 3, 4, 5, 6);
        drain();
        quiet = 1'b0;

        // Well-formed still windows with occasional disturbances
        write_all(48'd20000, 48'd10486, 48'd19661, 48'd1099512, 48'd42950, 48'd642908);
        push_imu(OP_CLEAR, 48'd0, 0, 0, 0, 0, 0, 0);
        ts = 48'd100;
        for (int i = 0; i < 80; i++)
        begin
            ts += 1000 + $urandom_range(5);
            jitter = ($urandom_range(11) == 0) ? 40000 : 0;
            if ($urandom_range(39) == 0)
                push_imu(OP_CLEAR, ts, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
            else
                push_imu(OP_SAMPLE, ts,
                         200 + jitter + $urandom_range(120) - 60,
                         -150 + $urandom_range(120) - 60,
                         100 + $urandom_range(120) - 60,
                         $urandom_range(80) - 40,
                         $urandom_range(80) - 40,
                         642908 + $urandom_range(80) - 40);
        end
        drain();

        // Opposite extremes of every register
        write_all(48'd1, 48'd0, 48'd0, 48'd0, 48'd0, 48'hFF_FFFF);
        ts = 48'd0;
        for (int i = 0; i < 20; i++)
        begin
            ts += $urandom_range(2);
            push_imu($urandom_range(7) == 0 ? OP_CLEAR : OP_SAMPLE, ts, rnd32(), rnd32(),
                     rnd32(), rnd32(), rnd32(), rnd32());
        end
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
design/isgbd_pkg.sv
design/isgbd_if.sv
design/isgbd_front.sv
design/isgbd_div.sv
design/isgbd_back.sv
design/imu_static_gyro_bias_detector.sv
dv/tb_imu_static_gyro_bias_detector.sv
